[sv/pse_pkg.sv]
// Shared types, constants and helper functions for the PNG stored-RGBA encoder.
package pse_pkg;

    localparam int unsigned MaxWidth   = 4096;
    localparam int unsigned MaxHeight  = 4096;
    localparam int unsigned DimW       = 13;
    localparam int unsigned FiltW      = 27;
    localparam int unsigned IdxW       = 8;
    localparam int unsigned FifoDepth  = 4;

    localparam logic [IdxW-1:0]  CfgWidth   = 8'd0;
    localparam logic [IdxW-1:0]  CfgHeight  = 8'd1;
    localparam logic [31:0]      CrcPoly    = 32'hedb88320;
    localparam logic [16:0]      AdlerMod   = 17'd65521;
    localparam logic [15:0]      BlockMax   = 16'hffff;
    localparam logic [5:0]       HdrLast    = 6'd42;
    localparam logic [5:0]       TrlLast    = 6'd19;
    localparam logic [5:0]       BlkLast    = 6'd4;

    typedef struct packed {
        logic       hdr;
        logic       row_start;
        logic       last;
        logic [7:0] px;
    } t_item;

    function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            x = (x >> 1) ^ (CrcPoly & {32{x[0]}});
        end
        return x;
    endfunction

    function automatic logic [7:0] be_byte(logic [31:0] v, logic [1:0] k);
        logic [7:0] r;
        unique case (k)
            2'd0: r = v[31:24];
            2'd1: r = v[23:16];
            2'd2: r = v[15:8];
            default: r = v[7:0];
        endcase
        return r;
    endfunction

    function automatic logic [DimW-1:0] clamp_dim(logic [DimW-1:0] v, logic [DimW-1:0] mx);
        logic [DimW-1:0] r;
        if (v == '0) begin
            r = DimW'(1);
        end else if (v > mx) begin
            r = mx;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

[sv/png_stored_rgba_encoder_unit.sv]
// Top level of the PNG stored-RGBA encoder: config registers, front, queue, back.
//
//  channel   handshake                     payload
//  config    i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//  pixels    i_valid / o_ready             i_pixel_byte
//  file      o_valid / i_ready             o_out_byte, o_run_last, o_file_last
//
// One output byte per cycle while the back end holds an item and the sink is ready;
// a frame adds 43 header bytes, 5 per stored block, 1 filter byte per row and 20
// trailer bytes to its pixel bytes. A 4-entry queue decouples input from output stalls.
// Sync active-low reset; writing width or height clears the frame in progress.
module png_stored_rgba_encoder_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [pse_pkg::IdxW-1:0] i_cfg_index,
    input  logic [pse_pkg::DimW-1:0] i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [7:0]               i_pixel_byte,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [7:0]               o_out_byte,
    output logic                     o_run_last,
    output logic                     o_file_last
);
    logic [pse_pkg::DimW-1:0]  r_width, r_height;
    logic [pse_pkg::DimW-1:0]  w_eff, h_eff;
    logic [pse_pkg::FiltW-1:0] r_filtered;
    logic                      clr, full, push, pop, q_valid;
    pse_pkg::t_item            f_item, q_item;

    assign o_cfg_ready = 1'b1;
    assign clr = i_cfg_valid && (i_cfg_index == pse_pkg::CfgWidth ||
                                 i_cfg_index == pse_pkg::CfgHeight);
    assign w_eff = pse_pkg::clamp_dim(r_width, pse_pkg::DimW'(pse_pkg::MaxWidth));
    assign h_eff = pse_pkg::clamp_dim(r_height, pse_pkg::DimW'(pse_pkg::MaxHeight));

    always_ff @(posedge i_clk) begin
        r_filtered <= ({12'd0, w_eff, 2'b00} + pse_pkg::FiltW'(1)) * {14'd0, h_eff};
        if (!i_rst_n) begin
            r_width  <= pse_pkg::DimW'(1);
            r_height <= pse_pkg::DimW'(1);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == pse_pkg::CfgWidth) begin
                r_width <= i_cfg_data;
            end else if (i_cfg_index == pse_pkg::CfgHeight) begin
                r_height <= i_cfg_data;
            end
        end
    end

    pse_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clr        (clr),
        .i_w          (w_eff),
        .i_h          (h_eff),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_pixel_byte (i_pixel_byte),
        .i_full       (full),
        .o_push       (push),
        .o_item       (f_item)
    );

    pse_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (clr),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    pse_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clr       (clr),
        .i_w         (w_eff),
        .i_h         (h_eff),
        .i_filtered  (r_filtered),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last),
        .o_file_last (o_file_last)
    );
endmodule

[sv/pse_front.sv]
// Front end: accepts pixel beats and tags header, row start and frame end.
module pse_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_clr,
    input  logic [pse_pkg::DimW-1:0] i_w,
    input  logic [pse_pkg::DimW-1:0] i_h,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [7:0]               i_pixel_byte,
    input  logic                     i_full,
    output logic                     o_push,
    output pse_pkg::t_item           o_item
);
    logic [13:0]               r_rbp, n_rbp;
    logic [pse_pkg::DimW-1:0]  r_rp, n_rp;
    logic                      r_hdr_done, n_hdr_done;
    logic [14:0]               w4;
    logic [14:0]               rbp_inc;
    logic [pse_pkg::DimW-1:0]  rp_inc;
    logic                      row_end;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign w4      = {i_w, 2'b00};
    assign rbp_inc = {1'b0, r_rbp} + 15'd1;
    assign rp_inc  = r_rp + pse_pkg::DimW'(1);
    assign row_end = (rbp_inc == w4);

    always_comb begin
        o_item.hdr       = !r_hdr_done;
        o_item.row_start = (r_rbp == '0);
        o_item.last      = row_end && (rp_inc == i_h);
        o_item.px        = i_pixel_byte;
        n_rbp      = r_rbp;
        n_rp       = r_rp;
        n_hdr_done = r_hdr_done;
        if (o_push) begin
            n_hdr_done = 1'b1;
            if (row_end) begin
                n_rbp = '0;
                if (o_item.last) begin
                    n_rp       = '0;
                    n_hdr_done = 1'b0;
                end else begin
                    n_rp = rp_inc;
                end
            end else begin
                n_rbp = rbp_inc[13:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_rbp      <= '0;
            r_rp       <= '0;
            r_hdr_done <= 1'b0;
        end else begin
            r_rbp      <= n_rbp;
            r_rp       <= n_rp;
            r_hdr_done <= n_hdr_done;
        end
    end
endmodule

[sv/pse_fifo.sv]
// Small queue of tagged items between front and back end.
module pse_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_clr,
    input  logic           i_push,
    input  pse_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output pse_pkg::t_item o_item
);
    localparam int unsigned AW = $clog2(pse_pkg::FifoDepth);

    pse_pkg::t_item r_mem [pse_pkg::FifoDepth];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(pse_pkg::FifoDepth));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n || i_clr) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + AW'(1);
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end
endmodule

[sv/pse_back.sv]
// Back end: byte sequencer for header, stored blocks, data, trailer, CRC and Adler-32.
module pse_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_clr,
    input  logic [pse_pkg::DimW-1:0]  i_w,
    input  logic [pse_pkg::DimW-1:0]  i_h,
    input  logic [pse_pkg::FiltW-1:0] i_filtered,
    input  logic                      i_q_valid,
    input  pse_pkg::t_item            i_q_item,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [7:0]                o_out_byte,
    output logic                      o_run_last,
    output logic                      o_file_last
);
    typedef enum logic [1:0] {S_HDR, S_Z, S_TRL} t_state;

    t_state                    r_state, n_state;
    logic                      r_act, n_act;
    logic [5:0]                r_cnt, n_cnt;
    logic                      r_need_filt, n_need_filt;
    pse_pkg::t_item            r_item, n_item;
    logic [31:0]               r_crc, n_crc;
    logic [15:0]               r_alo, n_alo, r_ahi, n_ahi;
    logic [15:0]               r_blk, n_blk;
    logic [pse_pkg::FiltW-1:0] r_strm, n_strm;
    logic                      r_ov;
    logic [7:0]                r_ob;
    logic                      r_rl, r_fl;

    logic                      adv, fin, fend, crc_on, crc_ff, take;
    logic [7:0]                ob, zd;
    logic [1:0]                k3;
    logic [10:0]               bq;
    logic [16:0]               br;
    logic [11:0]               blocks;
    logic [31:0]               idat;
    logic [15:0]               bcnt;
    logic                      bfinal;
    logic [16:0]               a1, a2;
    logic [15:0]               alo1;

    assign adv = r_act && (!r_ov || i_ready);
    assign k3  = 2'(r_cnt + 6'd3);
    assign zd  = r_need_filt ? 8'd0 : r_item.px;

    always_comb begin
        bq     = i_filtered[26:16];
        br     = {1'b0, i_filtered[15:0]} + {6'd0, bq};
        blocks = {1'b0, bq} + ((br == '0) ? 12'd0 : (br > 17'hffff) ? 12'd2 : 12'd1);
        idat   = 32'(i_filtered) + {18'd0, blocks, 2'b00} + {20'd0, blocks} + 32'd6;
        if (r_strm > pse_pkg::FiltW'(pse_pkg::BlockMax)) begin
            bcnt   = pse_pkg::BlockMax;
            bfinal = 1'b0;
        end else begin
            bcnt   = r_strm[15:0];
            bfinal = 1'b1;
        end
        a1   = {1'b0, r_alo} + {9'd0, zd};
        alo1 = (a1 >= pse_pkg::AdlerMod) ? 16'(a1 - pse_pkg::AdlerMod) : a1[15:0];
        a2   = {1'b0, r_ahi} + {1'b0, alo1};
    end

    always_comb begin
        n_state     = r_state;
        n_act       = r_act;
        n_cnt       = r_cnt;
        n_need_filt = r_need_filt;
        n_item      = r_item;
        n_alo       = r_alo;
        n_ahi       = r_ahi;
        n_blk       = r_blk;
        n_strm      = r_strm;
        fin         = 1'b0;
        fend        = 1'b0;
        crc_on      = 1'b0;
        crc_ff      = 1'b0;
        ob          = 8'd0;
        unique case (r_state)
            S_HDR: begin
                unique case (r_cnt) inside
                    [6'd0:6'd7]: begin
                        unique case (r_cnt[2:0])
                            3'd0: ob = 8'h89;
                            3'd1: ob = 8'h50;
                            3'd2: ob = 8'h4e;
                            3'd3: ob = 8'h47;
                            3'd4: ob = 8'h0d;
                            3'd5: ob = 8'h0a;
                            3'd6: ob = 8'h1a;
                            default: ob = 8'h0a;
                        endcase
                    end
                    [6'd8:6'd10]: ob = 8'd0;
                    6'd11: ob = 8'd13;
                    [6'd12:6'd15]: begin
                        crc_on = 1'b1;
                        crc_ff = (r_cnt == 6'd12);
                        ob = pse_pkg::be_byte(32'h49484452, r_cnt[1:0]);
                    end
                    [6'd16:6'd19]: begin
                        crc_on = 1'b1;
                        ob = pse_pkg::be_byte(32'(i_w), r_cnt[1:0]);
                    end
                    [6'd20:6'd23]: begin
                        crc_on = 1'b1;
                        ob = pse_pkg::be_byte(32'(i_h), r_cnt[1:0]);
                    end
                    6'd24: begin
                        crc_on = 1'b1;
                        ob = 8'd8;
                    end
                    6'd25: begin
                        crc_on = 1'b1;
                        ob = 8'd6;
                    end
                    [6'd26:6'd28]: crc_on = 1'b1;
                    [6'd29:6'd32]: ob = pse_pkg::be_byte(~r_crc, k3);
                    [6'd33:6'd36]: ob = pse_pkg::be_byte(idat, k3);
                    [6'd37:6'd40]: begin
                        crc_on = 1'b1;
                        crc_ff = (r_cnt == 6'd37);
                        ob = pse_pkg::be_byte(32'h49444154, k3);
                    end
                    6'd41: begin
                        crc_on = 1'b1;
                        ob = 8'h78;
                    end
                    default: begin
                        crc_on = 1'b1;
                        ob = 8'h01;
                    end
                endcase
                if (adv) begin
                    if (r_cnt == '0) begin
                        n_alo  = 16'd1;
                        n_ahi  = 16'd0;
                        n_blk  = 16'd0;
                        n_strm = i_filtered;
                    end
                    if (r_cnt == pse_pkg::HdrLast) begin
                        n_state = S_Z;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = r_cnt + 6'd1;
                    end
                end
            end
            S_Z: begin
                crc_on = 1'b1;
                if (r_blk == '0) begin
                    unique case (r_cnt[2:0])
                        3'd0: ob = {7'd0, bfinal};
                        3'd1: ob = bcnt[7:0];
                        3'd2: ob = bcnt[15:8];
                        3'd3: ob = ~bcnt[7:0];
                        default: ob = ~bcnt[15:8];
                    endcase
                    if (adv) begin
                        if (r_cnt == pse_pkg::BlkLast) begin
                            n_cnt = '0;
                            n_blk = bcnt;
                        end else begin
                            n_cnt = r_cnt + 6'd1;
                        end
                    end
                end else begin
                    ob = zd;
                    if (adv) begin
                        n_alo  = alo1;
                        n_ahi  = (a2 >= pse_pkg::AdlerMod) ? 16'(a2 - pse_pkg::AdlerMod)
                                                           : a2[15:0];
                        n_blk  = r_blk - 16'd1;
                        n_strm = r_strm - pse_pkg::FiltW'(1);
                        if (r_need_filt) begin
                            n_need_filt = 1'b0;
                        end else if (r_item.last) begin
                            n_state = S_TRL;
                            n_cnt   = '0;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                end
            end
            default: begin
                unique case (r_cnt) inside
                    [6'd0:6'd3]: begin
                        crc_on = 1'b1;
                        ob = pse_pkg::be_byte({r_ahi, r_alo}, r_cnt[1:0]);
                    end
                    [6'd4:6'd7], [6'd16:6'd19]: ob = pse_pkg::be_byte(~r_crc, r_cnt[1:0]);
                    [6'd12:6'd15]: begin
                        crc_on = 1'b1;
                        crc_ff = (r_cnt == 6'd12);
                        ob = pse_pkg::be_byte(32'h49454e44, r_cnt[1:0]);
                    end
                    default: ob = 8'd0;
                endcase
                if (adv) begin
                    if (r_cnt == pse_pkg::TrlLast) begin
                        fin  = 1'b1;
                        fend = 1'b1;
                    end else begin
                        n_cnt = r_cnt + 6'd1;
                    end
                end
            end
        endcase

        n_crc = r_crc;
        if (adv && crc_on) begin
            n_crc = pse_pkg::crc_byte(crc_ff ? 32'hffffffff : r_crc, ob);
        end

        take = i_q_valid && (!r_act || fin);
        if (fin) begin
            n_act = 1'b0;
        end
        if (take) begin
            n_act       = 1'b1;
            n_item      = i_q_item;
            n_state     = i_q_item.hdr ? S_HDR : S_Z;
            n_cnt       = '0;
            n_need_filt = i_q_item.row_start;
        end
    end

    assign o_pop       = take;
    assign o_valid     = r_ov;
    assign o_out_byte  = r_ob;
    assign o_run_last  = r_rl;
    assign o_file_last = r_fl;

    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_cnt       <= n_cnt;
        r_need_filt <= n_need_filt;
        if (adv) begin
            r_ob <= ob;
            r_rl <= fin;
            r_fl <= fend;
        end
        if (!i_rst_n || i_clr) begin
            r_state <= S_HDR;
            r_act   <= 1'b0;
            r_ov    <= 1'b0;
            r_crc   <= 32'hffffffff;
            r_alo   <= 16'd1;
            r_ahi   <= 16'd0;
            r_blk   <= '0;
            r_strm  <= '0;
        end else begin
            r_state <= n_state;
            r_act   <= n_act;
            r_crc   <= n_crc;
            r_alo   <= n_alo;
            r_ahi   <= n_ahi;
            r_blk   <= n_blk;
            r_strm  <= n_strm;
            if (adv) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end
endmodule
